### rtl/uvs_pkg.sv
// uvs_pkg: shared types, constants and arithmetic helpers of the UV-sphere vertex generator.
// Used by every module of the block; depends on nothing.
package uvs_pkg;

    localparam int SEG_W             = 11;
    localparam int TEX_BITS          = 16;
    localparam int TEX_W             = 17;
    localparam int POS_W             = 16;
    localparam int SIN_W             = 17;
    localparam int CFG_IDX_W         = 2;
    localparam int SIN_LAT           = 8;
    localparam int DEF_MAX_SEGMENTS  = 1024;
    localparam int DEF_FRACTION_BITS = 16;
    localparam logic [SEG_W-1:0] RST_COLUMNS = 11'd32;
    localparam logic [SEG_W-1:0] RST_ROWS    = 11'd16;

    // sin(pi/2*t) Taylor coefficients, Q30
    localparam logic signed [32:0] COEF_T9 = 33'sd172272;
    localparam logic signed [32:0] COEF_HORNER [4] = '{
        -33'sd5026995, 33'sd85569306, -33'sd693598669, 33'sd1686629713
    };
    localparam logic signed [32:0] Q30_ONE = 33'sd1073741824;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLUMNS,
        REG_ROWS
    } t_cfg_reg;

    typedef struct packed {
        logic [SEG_W-1:0] grid_column;
        logic [SEG_W-1:0] grid_row;
    } t_uvs_in;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [TEX_W-1:0]        tex_u;
        logic [TEX_W-1:0]        tex_v;
    } t_uvs_out;

    typedef struct packed {
        logic [SEG_W-1:0] col;
        logic [SEG_W-1:0] row;
        logic [SEG_W-1:0] ncol;
        logic [SEG_W-1:0] nrow;
    } t_uvs_item;

    // Q30 product, magnitude truncated toward zero
    function automatic logic signed [32:0] mul_q30(logic signed [32:0] a, logic [30:0] b);
        logic        neg;
        logic [32:0] mag;
        logic [61:0] prod;
        logic [31:0] m;
        neg  = a[32];
        mag  = neg ? 33'(-a) : 33'(a);
        prod = 62'(mag[30:0]) * 62'(b);
        m    = prod[61:30];
        return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

endpackage

### rtl/uvs_front.sv
// uvs_front: configuration registers, segment and index clamping of accepted grid points.
// Depends on uvs_pkg.
module uvs_front #(
    parameter int MAX_SEGMENTS = uvs_pkg::DEF_MAX_SEGMENTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [uvs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [uvs_pkg::SEG_W-1:0]       i_cfg_data,
    output logic                            o_cfg_ready,
    input  uvs_pkg::t_uvs_in                i_point,
    output uvs_pkg::t_uvs_item              o_item
);
    import uvs_pkg::*;

    logic [SEG_W-1:0] r_columns, n_columns;
    logic [SEG_W-1:0] r_rows, n_rows;
    logic [SEG_W-1:0] seg_n, seg_m;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_columns = r_columns;
        n_rows    = r_rows;
        if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_COLUMNS: n_columns = i_cfg_data;
                REG_ROWS:    n_rows    = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= RST_COLUMNS;
            r_rows    <= RST_ROWS;
        end else begin
            r_columns <= n_columns;
            r_rows    <= n_rows;
        end
    end

    always_comb begin
        priority if (r_columns == '0) begin
            seg_n = SEG_W'(1);
        end else if (int'(r_columns) > MAX_SEGMENTS) begin
            seg_n = SEG_W'(MAX_SEGMENTS);
        end else begin
            seg_n = r_columns;
        end
        priority if (r_rows == '0) begin
            seg_m = SEG_W'(1);
        end else if (int'(r_rows) > MAX_SEGMENTS) begin
            seg_m = SEG_W'(MAX_SEGMENTS);
        end else begin
            seg_m = r_rows;
        end
        o_item.ncol = seg_n;
        o_item.nrow = seg_m;
        o_item.col  = (i_point.grid_column > seg_n) ? seg_n : i_point.grid_column;
        o_item.row  = (i_point.grid_row > seg_m) ? seg_m : i_point.grid_row;
    end

endmodule

### rtl/uvs_queue.sv
// uvs_queue: two-entry queue between front and back; drains one beat per cycle.
// Depends on uvs_pkg.
module uvs_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  uvs_pkg::t_uvs_item  i_item,
    output logic                o_valid,
    output uvs_pkg::t_uvs_item  o_item,
    output logic                o_full
);
    import uvs_pkg::*;

    t_uvs_item   r_mem [2];
    logic        r_wr, r_rd;
    logic [1:0]  r_count;
    logic        pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign pop     = o_valid;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (pop)    r_rd <= ~r_rd;
            r_count <= r_count + 2'(i_push) - 2'(pop);
        end
    end

endmodule

### rtl/uvs_div.sv
// uvs_div: pipelined restoring divider, one quotient bit per stage.
// Depends on uvs_pkg.
module uvs_div #(
    parameter int LAT = 17,
    parameter int DW  = 28
) (
    input  logic                        i_clk,
    input  logic [DW-1:0]               i_num,
    input  logic [uvs_pkg::SEG_W-1:0]   i_den,
    output logic [LAT-1:0]              o_quo
);
    import uvs_pkg::*;

    logic [DW-1:0]    r_rem [LAT];
    logic [LAT-1:0]   r_quo [LAT];
    logic [SEG_W-1:0] r_den [LAT];

    for (genvar s = 0; s < LAT; s++) begin : g_stage
        logic [DW-1:0]    rem_in, n_rem, cmp;
        logic [LAT-1:0]   quo_in, n_quo;
        logic [SEG_W-1:0] den_in;

        if (s == 0) begin : g_first
            assign rem_in = i_num;
            assign quo_in = '0;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign quo_in = r_quo[s-1];
            assign den_in = r_den[s-1];
        end

        always_comb begin
            cmp   = DW'(den_in) << (LAT - 1 - s);
            n_rem = rem_in;
            n_quo = quo_in;
            if (rem_in >= cmp) begin
                n_rem = rem_in - cmp;
                n_quo[LAT-1-s] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s] <= n_rem;
            r_quo[s] <= n_quo;
            r_den[s] <= den_in;
        end
    end

    assign o_quo = r_quo[LAT-1];

endmodule

### rtl/uvs_sine.sv
// uvs_sine: pipelined Q15 sine of a phase, quadrant fold and Horner polynomial in Q30.
// Depends on uvs_pkg.
module uvs_sine #(
    parameter int FRACTION_BITS = uvs_pkg::DEF_FRACTION_BITS
) (
    input  logic                                i_clk,
    input  logic [FRACTION_BITS:0]              i_phase,
    output logic signed [uvs_pkg::SIN_W-1:0]    o_sin
);
    import uvs_pkg::*;

    localparam int F = FRACTION_BITS;

    logic [1:0]          quad;
    logic [F-1:0]        arg;
    logic [30:0]         r0_t, r1_t, r1_t2, r5_t;
    logic [1:0]          r0_q, r1_q, r5_q, r6_q;
    logic [30:0]         r_h_t  [4];
    logic [30:0]         r_h_t2 [4];
    logic [1:0]          r_h_q  [4];
    logic signed [32:0]  r_acc  [4];
    logic signed [32:0]  r6_s, t2_full, s_clamp;
    logic [17:0]         q_mag;

    always_comb begin
        quad = i_phase[F:F-1];
        arg  = quad[0] ? (F'(1) << (F - 1)) - F'(i_phase[F-2:0]) : F'(i_phase[F-2:0]);
    end

    always_ff @(posedge i_clk) begin
        r0_t <= 31'(arg) << (31 - F);
        r0_q <= quad;
    end

    assign t2_full = mul_q30($signed({2'b00, r0_t}), r0_t);

    always_ff @(posedge i_clk) begin
        r1_t  <= r0_t;
        r1_q  <= r0_q;
        r1_t2 <= t2_full[30:0];
    end

    for (genvar k = 0; k < 4; k++) begin : g_horner
        logic signed [32:0] acc_in;
        logic [30:0]        t_in, t2_in;
        logic [1:0]         q_in;
        if (k == 0) begin : g_first
            assign acc_in = COEF_T9;
            assign t_in   = r1_t;
            assign t2_in  = r1_t2;
            assign q_in   = r1_q;
        end else begin : g_next
            assign acc_in = r_acc[k-1];
            assign t_in   = r_h_t[k-1];
            assign t2_in  = r_h_t2[k-1];
            assign q_in   = r_h_q[k-1];
        end
        always_ff @(posedge i_clk) begin
            r_acc[k]  <= COEF_HORNER[k] + mul_q30(acc_in, t2_in);
            r_h_t[k]  <= t_in;
            r_h_t2[k] <= t2_in;
            r_h_q[k]  <= q_in;
        end
    end

    assign r5_t = r_h_t[3];
    assign r5_q = r_h_q[3];

    always_ff @(posedge i_clk) begin
        r6_s <= mul_q30(r_acc[3], r5_t);
        r6_q <= r5_q;
    end

    always_comb begin
        priority if (r6_s < 0) begin
            s_clamp = '0;
        end else if (r6_s > Q30_ONE) begin
            s_clamp = Q30_ONE;
        end else begin
            s_clamp = r6_s;
        end
        q_mag = 18'((s_clamp + 33'sd16384) >>> 15);
    end

    always_ff @(posedge i_clk) begin
        o_sin <= r6_q[1] ? -$signed(q_mag[SIN_W-1:0]) : $signed(q_mag[SIN_W-1:0]);
    end

endmodule

### rtl/uvs_back.sv
// uvs_back: fraction dividers, four sine units and the position products of each grid point.
// Depends on uvs_pkg, uvs_div and uvs_sine.
module uvs_back #(
    parameter int FRACTION_BITS = uvs_pkg::DEF_FRACTION_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  uvs_pkg::t_uvs_item  i_item,
    output logic                o_valid,
    output uvs_pkg::t_uvs_out   o_vertex
);
    import uvs_pkg::*;

    localparam int F   = FRACTION_BITS;
    localparam int LAT = ((F > TEX_BITS) ? F : TEX_BITS) + 1;
    localparam int DW  = SEG_W + LAT;
    localparam int PW  = F + 1;
    localparam int VL  = LAT + SIN_LAT;

    logic [DW-1:0]           num_u, num_v, num_tu, num_tv;
    logic [LAT-1:0]          quo_u, quo_v, quo_tu, quo_tv;
    logic [PW-1:0]           ph_su, ph_cu, ph_sv, ph_cv;
    logic signed [SIN_W-1:0] sin_u, cos_u, sin_v, cos_v;
    logic [VL-1:0]           r_vld;
    logic [TEX_W-1:0]        r_tu [SIN_LAT];
    logic [TEX_W-1:0]        r_tv [SIN_LAT];
    logic                    r_out_vld;
    t_uvs_out                r_out;

    function automatic logic signed [POS_W-1:0] sat_pos(logic signed [19:0] v);
        if (v > 20'sd32767)  return 16'sd32767;
        if (v < -20'sd32768) return -16'sd32768;
        return v[POS_W-1:0];
    endfunction

    function automatic logic signed [19:0] mul_q15(logic signed [SIN_W-1:0] a,
                                                   logic signed [SIN_W-1:0] b);
        logic              neg;
        logic [SIN_W-1:0]  ma, mb;
        logic [33:0]       p;
        logic [18:0]       m;
        neg = a[SIN_W-1] ^ b[SIN_W-1];
        ma  = a[SIN_W-1] ? SIN_W'(-a) : SIN_W'(a);
        mb  = b[SIN_W-1] ? SIN_W'(-b) : SIN_W'(b);
        p   = 34'(ma) * 34'(mb);
        m   = 19'((p + 34'd16384) >> 15);
        return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    always_comb begin
        num_u  = (DW'(i_item.col) << F) + DW'(i_item.ncol >> 1);
        num_v  = (DW'(i_item.row) << F) + DW'(i_item.nrow >> 1);
        num_tu = (DW'(i_item.ncol - i_item.col) << TEX_BITS) + DW'(i_item.ncol >> 1);
        num_tv = (DW'(i_item.row) << TEX_BITS) + DW'(i_item.nrow >> 1);
    end

    uvs_div #(.LAT(LAT), .DW(DW)) u_div_u (
        .i_clk(i_clk), .i_num(num_u), .i_den(i_item.ncol), .o_quo(quo_u));
    uvs_div #(.LAT(LAT), .DW(DW)) u_div_v (
        .i_clk(i_clk), .i_num(num_v), .i_den(i_item.nrow), .o_quo(quo_v));
    uvs_div #(.LAT(LAT), .DW(DW)) u_div_tu (
        .i_clk(i_clk), .i_num(num_tu), .i_den(i_item.ncol), .o_quo(quo_tu));
    uvs_div #(.LAT(LAT), .DW(DW)) u_div_tv (
        .i_clk(i_clk), .i_num(num_tv), .i_den(i_item.nrow), .o_quo(quo_tv));

    always_comb begin
        ph_su = {quo_u[PW-2:0], 1'b0};
        ph_cu = ph_su + (PW'(1) << (F - 1));
        ph_sv = quo_v[PW-1:0];
        ph_cv = ph_sv + (PW'(1) << (F - 1));
    end

    uvs_sine #(.FRACTION_BITS(F)) u_sin_u (.i_clk(i_clk), .i_phase(ph_su), .o_sin(sin_u));
    uvs_sine #(.FRACTION_BITS(F)) u_cos_u (.i_clk(i_clk), .i_phase(ph_cu), .o_sin(cos_u));
    uvs_sine #(.FRACTION_BITS(F)) u_sin_v (.i_clk(i_clk), .i_phase(ph_sv), .o_sin(sin_v));
    uvs_sine #(.FRACTION_BITS(F)) u_cos_v (.i_clk(i_clk), .i_phase(ph_cv), .o_sin(cos_v));

    always_ff @(posedge i_clk) begin
        r_tu[0] <= quo_tu[TEX_W-1:0];
        r_tv[0] <= quo_tv[TEX_W-1:0];
        for (int i = 1; i < SIN_LAT; i++) begin
            r_tu[i] <= r_tu[i-1];
            r_tv[i] <= r_tv[i-1];
        end
        r_out.pos_x <= sat_pos(mul_q15(cos_u, sin_v));
        r_out.pos_y <= sat_pos(20'(cos_v));
        r_out.pos_z <= sat_pos(mul_q15(sin_u, sin_v));
        r_out.tex_u <= r_tu[SIN_LAT-1];
        r_out.tex_v <= r_tv[SIN_LAT-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[VL-2:0], i_valid};
            r_out_vld <= r_vld[VL-1];
        end
    end

    assign o_valid  = r_out_vld;
    assign o_vertex = r_out;

endmodule

### rtl/uv_sphere_vertex_generator.sv
// UV-sphere vertex generator: turns a grid column and row into a unit-sphere position
// and texture coordinates. Depends on uvs_pkg, uvs_front, uvs_queue, uvs_back.
//
// Usage:
//   Input: drive i_point and raise start; the beat is taken at a rising edge with
//   start high and busy low. busy stays low in operation (the back end drains its
//   queue every cycle) and is high only while i_rst_n is low.
//   Output: o_vertex is valid for exactly one cycle with o_valid; the receiver must
//   take it then, there is no back-pressure.
//   Configuration: i_cfg_index / i_cfg_data with i_cfg_valid; o_cfg_ready is always
//   high. Index 0 is columns_used, index 1 rows_used, other indexes are ignored.
//   Write only while no point is in flight.
//   Pipeline from accept to o_valid: one queue stage, one restoring divider stage per
//   quotient bit, eight sine stages and one product stage.
//   Throughput: one point per cycle, fully pipelined.
//   Reset (synchronous, i_rst_n low): registers return to 32 columns and 16 rows,
//   queue and in-flight points are dropped.
module uv_sphere_vertex_generator #(
    parameter int MAX_SEGMENTS  = uvs_pkg::DEF_MAX_SEGMENTS,
    parameter int FRACTION_BITS = uvs_pkg::DEF_FRACTION_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  uvs_pkg::t_uvs_in                i_point,
    output logic                            o_valid,
    output uvs_pkg::t_uvs_out               o_vertex,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [uvs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [uvs_pkg::SEG_W-1:0]       i_cfg_data
);
    import uvs_pkg::*;

    t_uvs_item front_item, q_item;
    logic      accept, q_valid, q_full;

    assign busy   = q_full | ~i_rst_n;
    assign accept = start & ~busy;

    uvs_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_point     (i_point),
        .o_item      (front_item)
    );

    uvs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_item  (front_item),
        .o_valid (q_valid),
        .o_item  (q_item),
        .o_full  (q_full)
    );

    uvs_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_item   (q_item),
        .o_valid  (o_valid),
        .o_vertex (o_vertex)
    );

endmodule

### rtl/uvs_checker.sv
// uvs_checker: port-level assertions of the UV-sphere vertex generator, bound to the top.
// Depends on uvs_pkg and uv_sphere_vertex_generator.
module uvs_checker #(
    parameter int FRACTION_BITS = uvs_pkg::DEF_FRACTION_BITS
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            o_valid,
    input uvs_pkg::t_uvs_out               o_vertex
);
    import uvs_pkg::*;

    localparam int LATENCY = ((FRACTION_BITS > TEX_BITS) ? FRACTION_BITS : TEX_BITS) + 11;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("vertex beat without matching input beat");

    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised outside reset");

    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("vertex beat right after reset");

    a_tex_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_vertex.tex_u <= 17'd65536) && (o_vertex.tex_v <= 17'd65536))
        else $error("texture coordinate above one");

endmodule

bind uv_sphere_vertex_generator uvs_checker #(.FRACTION_BITS(FRACTION_BITS)) u_uvs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_vertex (o_vertex)
);

### test/uv_sphere_vertex_generator_tb.sv
// Testbench for uv_sphere_vertex_generator: random and directed grid points under several
// segment settings, each vertex checked against a fixed-point predictor. Needs uvs_pkg.
`timescale 1ns / 1ps

module uv_sphere_vertex_generator_tb;
    import uvs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;
    localparam int FB         = DEF_FRACTION_BITS;
    localparam int DRAIN_WAIT = 40;
    localparam int CYCLE_LIMIT = 400000;

    class vertex_scoreboard;
        t_uvs_out pending[$];
        int       errors;
        int       checked;

        function new();
            errors  = 0;
            checked = 0;
        endfunction

        function automatic longint mul_trunc_q30(longint a, longint b);
            if (a < 0) return -(((-a) * b) >>> 30);
            return (a * b) >>> 30;
        endfunction

        function automatic int sine_q15(longint phase);
            longint p, w, a, t, t2, acc, s;
            int     quad, q;
            p    = phase & ((longint'(1) << (FB + 1)) - 1);
            quad = int'(p >> (FB - 1));
            w    = p & ((longint'(1) << (FB - 1)) - 1);
            a    = (quad & 1) ? (longint'(1) << (FB - 1)) - w : w;
            t    = a << (31 - FB);
            t2   = mul_trunc_q30(t, t);
            acc  = longint'(COEF_T9);
            for (int i = 0; i < 4; i++)
                acc = longint'(COEF_HORNER[i]) + mul_trunc_q30(acc, t2);
            s = mul_trunc_q30(acc, t);
            if (s < 0) s = 0;
            if (s > longint'(Q30_ONE)) s = longint'(Q30_ONE);
            q = int'((s + 16384) >>> 15);
            return (quad & 2) ? -q : q;
        endfunction

        function automatic int mul_round_q15(int a, int b);
            longint ma, mb;
            int     m;
            ma = (a < 0) ? -longint'(a) : longint'(a);
            mb = (b < 0) ? -longint'(b) : longint'(b);
            m  = int'((ma * mb + 16384) >>> 15);
            return ((a < 0) != (b < 0)) ? -m : m;
        endfunction

        function automatic logic [POS_W-1:0] saturate(int v);
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return v[POS_W-1:0];
        endfunction

        function void note_point(t_uvs_in pt, int cols_reg, int rows_reg);
            longint   n, m, c, r, uq, vq;
            int       cu, su, sv, cv;
            t_uvs_out e;
            n = (cols_reg == 0) ? 1 : (cols_reg > DEF_MAX_SEGMENTS ? DEF_MAX_SEGMENTS : cols_reg);
            m = (rows_reg == 0) ? 1 : (rows_reg > DEF_MAX_SEGMENTS ? DEF_MAX_SEGMENTS : rows_reg);
            c = pt.grid_column;
            r = pt.grid_row;
            if (c > n) c = n;
            if (r > m) r = m;
            uq = ((c << FB) + n / 2) / n;
            vq = ((r << FB) + m / 2) / m;
            cu = sine_q15(2 * uq + (longint'(1) << (FB - 1)));
            su = sine_q15(2 * uq);
            sv = sine_q15(vq);
            cv = sine_q15(vq + (longint'(1) << (FB - 1)));
            e.pos_x = saturate(mul_round_q15(cu, sv));
            e.pos_y = saturate(cv);
            e.pos_z = saturate(mul_round_q15(su, sv));
            e.tex_u = TEX_W'(((n - c) * 65536 + n / 2) / n);
            e.tex_v = TEX_W'((r * 65536 + m / 2) / m);
            pending.insert(pending.size(), e);
        endfunction

        function void check_vertex(t_uvs_out got);
            t_uvs_out e;
            if (pending.size() == 0) begin
                $display("%0t: vertex with nothing expected, actual %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.pos_x !== e.pos_x) begin
                $display("%0t: pos_x expected %0d actual %0d", $time, e.pos_x, got.pos_x);
                errors++;
            end
            if (got.pos_y !== e.pos_y) begin
                $display("%0t: pos_y expected %0d actual %0d", $time, e.pos_y, got.pos_y);
                errors++;
            end
            if (got.pos_z !== e.pos_z) begin
                $display("%0t: pos_z expected %0d actual %0d", $time, e.pos_z, got.pos_z);
                errors++;
            end
            if (got.tex_u !== e.tex_u) begin
                $display("%0t: tex_u expected %0d actual %0d", $time, e.tex_u, got.tex_u);
                errors++;
            end
            if (got.tex_v !== e.tex_v) begin
                $display("%0t: tex_v expected %0d actual %0d", $time, e.tex_v, got.tex_v);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_uvs_in              i_point;
    logic                 o_valid;
    t_uvs_out             o_vertex;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [SEG_W-1:0]     i_cfg_data;

    vertex_scoreboard sb;
    int cols_shadow;
    int rows_shadow;
    int cycle_count = 0;
    int phase_count;

    uv_sphere_vertex_generator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_point     (i_point),
        .o_valid     (o_valid),
        .o_vertex    (o_vertex),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            sb.note_point(i_point, cols_shadow, rows_shadow);
        if (i_rst_n && o_valid)
            sb.check_vertex(o_vertex);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_point(input logic [SEG_W-1:0] col, input logic [SEG_W-1:0] row);
        start           <= 1'b1;
        i_point.grid_column <= col;
        i_point.grid_row    <= row;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_gap(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain_pipe();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SEG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_COLUMNS) cols_shadow = val;
        else if (idx == REG_ROWS) rows_shadow = val;
    endtask

    task automatic random_points(input int count);
        int burst;
        int col_lim;
        int row_lim;
        logic [SEG_W-1:0] col, row;
        col_lim = (cols_shadow == 0) ? 1 : (cols_shadow > 1024 ? 1024 : cols_shadow);
        row_lim = (rows_shadow == 0) ? 1 : (rows_shadow > 1024 ? 1024 : rows_shadow);
        burst = $urandom_range(1, 30);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                col = SEG_W'($urandom);
                row = SEG_W'($urandom);
            end else begin
                col = SEG_W'($urandom_range(0, col_lim));
                row = SEG_W'($urandom_range(0, row_lim));
            end
            send_point(col, row);
            burst--;
            if (burst == 0) begin
                if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
                burst = $urandom_range(1, 30);
            end
        end
    endtask

    initial begin
        sb          = new();
        cols_shadow = RST_COLUMNS;
        rows_shadow = RST_ROWS;
        phase_count = 0;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_point     <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_COLUMNS;
        i_cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values, poles, equator, clamped indexes
        send_point(0, 0);
        send_point(32, 16);
        send_point(8, 8);
        send_point(16, 4);
        send_point(24, 12);
        send_point(31, 15);
        send_point(33, 17);
        send_point(11'h7FF, 11'h7FF);
        send_point(11'h7FF, 0);
        send_point(0, 11'h7FF);
        send_point(4, 1);
        send_point(11'h400, 11'h400);
        drain_pipe();

        write_reg(CFG_IDX_SPARE_A, 11'd5);
        write_reg(CFG_IDX_SPARE_B, 11'h7FF);
        send_point(8, 8);
        send_point(32, 2);
        drain_pipe();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin write_reg(REG_COLUMNS, 11'd1);    write_reg(REG_ROWS, 11'd1);    end
                1: begin write_reg(REG_COLUMNS, 11'd1024); write_reg(REG_ROWS, 11'd1024); end
                2: begin write_reg(REG_COLUMNS, 11'd0);    write_reg(REG_ROWS, 11'd0);    end
                3: begin write_reg(REG_COLUMNS, 11'h7FF);  write_reg(REG_ROWS, 11'd1025); end
                4: begin write_reg(REG_COLUMNS, 11'd3);    write_reg(REG_ROWS, 11'd1023); end
                default: begin
                    write_reg(REG_COLUMNS, SEG_W'($urandom_range(1, 1024)));
                    write_reg(REG_ROWS, SEG_W'($urandom_range(1, 1024)));
                end
            endcase
            send_point(0, 0);
            send_point(11'h7FF, 11'h7FF);
            random_points(170);
            drain_pipe();
            phase_count++;
        end

        $display("checked %0d vertices over %0d segment settings plus reset defaults",
                 sb.checked, phase_count);
        $display("errors: %0d", sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d vertices still expected", sb.pending.size());
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

### uv_sphere_vertex_generator.f
rtl/uvs_pkg.sv
rtl/uvs_front.sv
rtl/uvs_queue.sv
rtl/uvs_div.sv
rtl/uvs_sine.sv
rtl/uvs_back.sv
rtl/uv_sphere_vertex_generator.sv
rtl/uvs_checker.sv
test/uv_sphere_vertex_generator_tb.sv
